// ===== src/prrq_pkg.sv =====
// ----------------------------------------------------------------------------
// prrq_pkg
// Shared types, codes and helpers of the priority round robin ready queue.
// ----------------------------------------------------------------------------
package prrq_pkg;

  localparam int NUM_PROCESSES = 16;
  localparam int NUM_LEVELS    = 8;
  localparam int PID_W         = $clog2(NUM_PROCESSES);
  localparam int LVL_W         = $clog2(NUM_LEVELS);

  typedef logic [PID_W-1:0]      pid_t;
  typedef logic [LVL_W-1:0]      lvl_t;
  typedef logic [NUM_LEVELS-1:0] mask_t;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NONE_READY = 2'd1,
    ST_ALREADY    = 2'd2,
    ST_NOT_QUEUED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_LINK
  } state_t;

  // highest set bit of the occupancy mask
  function automatic lvl_t top_level(mask_t m);
    lvl_t r;
    r = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (m[i]) r = lvl_t'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/priority_round_robin_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_ready_queue_unit
// Eight level ready queue with a circular linked ring of processes per level.
// ----------------------------------------------------------------------------
// Usage: one input channel (cmd, process_id, priority_level with in_valid and
// in_stall) and one result channel (chosen_process, status with out_valid and
// out_stall). Every command gives exactly one result item.
// The ring links and process levels sit in three synchronous memories with
// registered reads; each command reads its entries, then writes back.
// A command passes S_READ, then S_EXEC, which waits while the output is held
// and loads the result register. An add to a level that already holds
// processes also passes S_LINK to write the second pair of links.
// in_stall is high while a command is in work, so one item is taken at a time.
// The result sits in an output register; while out_stall holds it, the next
// command is still accepted and read, and waits before its write back.
// Reset empties every level, clears all queued flags and sets the active
// process to zero; the link memories are not cleared.
// ----------------------------------------------------------------------------
module priority_round_robin_ready_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  prrq_pkg::pid_t       process_id,
  input  logic [2:0]           priority_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prrq_pkg::pid_t       chosen_process,
  output logic [1:0]           status
);
  import prrq_pkg::*;

  state_t state, state_next;
  cmd_t   cmd_r;
  pid_t   pid_r;
  lvl_t   lvl_r;
  pid_t   t_r;

  logic [NUM_PROCESSES-1:0] queued;
  pid_t  head [NUM_LEVELS];
  mask_t mask, mask_next;
  pid_t  active;

  pid_t next_mem [NUM_PROCESSES];
  pid_t prev_mem [NUM_PROCESSES];
  lvl_t lvl_mem  [NUM_PROCESSES];
  pid_t next_rd, prev_rd;
  lvl_t lvl_rd;
  pid_t next_ra, prev_ra;

  logic next_we, prev_we, lvl_we, head_we, q_set, q_clr, active_we, out_load, t_load;
  pid_t next_wa, next_wd, prev_wa, prev_wd, head_wd, res_chosen;
  lvl_t head_wa, top;
  status_t res_status;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign top      = top_level(mask);
  assign next_ra  = (cmd_r == CMD_DISPATCH) ? active : pid_r;
  assign prev_ra  = (cmd_r == CMD_ADD) ? head[lvl_r] : pid_r;

  always_ff @(posedge clk) begin
    next_rd <= next_mem[next_ra];
    prev_rd <= prev_mem[prev_ra];
    lvl_rd  <= lvl_mem[next_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (lvl_we) lvl_mem[pid_r] <= lvl_r;
  end

  always_comb begin
    state_next = state;
    mask_next  = mask;
    next_we = 1'b0; next_wa = pid_r; next_wd = pid_r;
    prev_we = 1'b0; prev_wa = pid_r; prev_wd = pid_r;
    lvl_we = 1'b0; head_we = 1'b0; head_wa = lvl_r; head_wd = pid_r;
    q_set = 1'b0; q_clr = 1'b0; active_we = 1'b0; out_load = 1'b0; t_load = 1'b0;
    res_chosen = '0; res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_r)
            CMD_ADD: begin
              if (queued[pid_r]) begin
                res_status = ST_ALREADY;
              end else begin
                q_set   = 1'b1;
                lvl_we  = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                if (!mask[lvl_r]) begin
                  head_we          = 1'b1;
                  mask_next[lvl_r] = 1'b1;
                end else begin
                  next_wd    = head[lvl_r];
                  prev_wd    = prev_rd;
                  t_load     = 1'b1;
                  state_next = S_LINK;
                end
              end
            end
            CMD_REMOVE: begin
              if (!queued[pid_r]) begin
                res_status = ST_NOT_QUEUED;
              end else begin
                q_clr = 1'b1;
                if (next_rd == pid_r) begin
                  mask_next[lvl_rd] = 1'b0;
                end else begin
                  head_we = 1'b1;
                  head_wa = lvl_rd;
                  head_wd = next_rd;
                  prev_we = 1'b1;
                  prev_wa = next_rd;
                  prev_wd = prev_rd;
                  next_we = 1'b1;
                  next_wa = prev_rd;
                  next_wd = next_rd;
                end
              end
            end
            CMD_DISPATCH: begin
              if (mask == '0) begin
                res_status = ST_NONE_READY;
              end else begin
                active_we  = 1'b1;
                res_chosen = (top == lvl_rd) ? next_rd : head[top];
              end
            end
            default: ;
          endcase
        end
      end
      S_LINK: begin
        next_we    = 1'b1;
        next_wa    = t_r;
        prev_we    = 1'b1;
        prev_wa    = head[lvl_r];
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      queued    <= '0;
      mask      <= '0;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mask  <= mask_next;
      if (q_set) queued[pid_r] <= 1'b1;
      if (q_clr) queued[pid_r] <= 1'b0;
      if (active_we) active <= res_chosen;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r <= cmd_t'(cmd);
      pid_r <= process_id;
      lvl_r <= lvl_t'(priority_level);
    end
    if (t_load) t_r <= prev_rd;
    if (head_we) head[head_wa] <= head_wd;
    if (out_load) begin
      chosen_process <= res_chosen;
      status         <= res_status;
    end
  end

endmodule

// ===== src/prrq_checker.sv =====
// ----------------------------------------------------------------------------
// prrq_checker
// Port level checks of the ready queue unit, bound to the queue unit module.
// ----------------------------------------------------------------------------
module prrq_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input prrq_pkg::pid_t       chosen_process,
  input logic [1:0]           status
);
  import prrq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_process) && $stable(status))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> chosen_process == '0)
    else $error("failed command chose a process");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left block busy");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid || out_stall || $past(out_valid))
    else $error("result appeared too early");

endmodule

bind priority_round_robin_ready_queue_unit prrq_checker u_prrq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .chosen_process(chosen_process), .status(status)
);

// ===== test/priority_round_robin_ready_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_ready_queue_unit_tb
// Self-checking testbench of the priority round robin ready queue. Commands go
// in through the valid/stall input channel. Each accepted item is run through
// a local model of the level rings, the occupancy mask and the active process.
// Each result item is compared with the oldest predicted result. A directed
// sequence covers the error codes, stale dispatch and the level extremes.
// Random sequences follow, biased towards valid add and remove commands, with
// changing idle and stall rates on both sides.
// ----------------------------------------------------------------------------
module priority_round_robin_ready_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prrq_pkg::*;

  typedef struct packed {
    pid_t    chosen;
    status_t st;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] cmd = CMD_NOP;
  pid_t       process_id = '0;
  logic [2:0] priority_level = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pid_t       chosen_process;
  logic [1:0] status;

  // local copy of the scheduler state
  pid_t  ring_next [NUM_PROCESSES];
  pid_t  ring_prev [NUM_PROCESSES];
  lvl_t  proc_lvl [NUM_PROCESSES];
  logic  is_queued [NUM_PROCESSES];
  pid_t  head_of [NUM_LEVELS];
  mask_t ready_mask;
  pid_t  running;

  sched_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  priority_round_robin_ready_queue_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .process_id(process_id), .priority_level(priority_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .chosen_process(chosen_process), .status(status)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic sched_result_t schedule(cmd_t c, pid_t p, lvl_t lv);
    sched_result_t r;
    pid_t h, t, n, pr;
    lvl_t top;
    r.chosen = '0;
    r.st = ST_OK;
    case (c)
      CMD_ADD: begin
        if (is_queued[p]) begin
          r.st = ST_ALREADY;
        end else begin
          if (!ready_mask[lv]) begin
            head_of[lv] = p;
            ring_next[p] = p;
            ring_prev[p] = p;
            ready_mask[lv] = 1'b1;
          end else begin
            h = head_of[lv];
            t = ring_prev[h];
            ring_next[p] = h;
            ring_prev[p] = t;
            ring_next[t] = p;
            ring_prev[h] = p;
          end
          proc_lvl[p] = lv;
          is_queued[p] = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!is_queued[p]) begin
          r.st = ST_NOT_QUEUED;
        end else begin
          n = ring_next[p];
          pr = ring_prev[p];
          if (n == p) begin
            ready_mask[proc_lvl[p]] = 1'b0;
          end else begin
            head_of[proc_lvl[p]] = n;
            ring_prev[n] = pr;
            ring_next[pr] = n;
          end
          is_queued[p] = 1'b0;
        end
      end
      CMD_DISPATCH: begin
        if (ready_mask == '0) begin
          r.st = ST_NONE_READY;
        end else begin
          top = '0;
          for (int i = 0; i < NUM_LEVELS; i++) if (ready_mask[i]) top = lvl_t'(i);
          if (top == proc_lvl[running]) r.chosen = ring_next[running];
          else r.chosen = head_of[top];
          running = r.chosen;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(cmd_t c, pid_t p, logic [2:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    process_id <= p;
    priority_level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(schedule(c, p, lv));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %0d/%0d", chosen_process, status);
      end else begin
        exp_r = pending_results.pop_front();
        if (chosen_process !== exp_r.chosen || status !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: chosen exp %0d got %0d, status exp %0d got %0d",
                     exp_r.chosen, chosen_process, exp_r.st, status);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(CMD_ADD, 4'd0, 3'd0);
    send_item(CMD_DISPATCH, 4'd9, 3'd5);
    send_item(CMD_ADD, 4'd0, 3'd3);
    send_item(CMD_REMOVE, 4'd5, 3'd7);
    send_item(CMD_ADD, 4'd15, 3'd7);
    send_item(CMD_ADD, 4'd3, 3'd7);
    send_item(CMD_ADD, 4'd9, 3'd7);
    send_item(CMD_ADD, 4'd6, 3'd1);
    repeat (4) send_item(CMD_DISPATCH, 4'd15, 3'd7);
    send_item(CMD_REMOVE, 4'd3, 3'd0);
    send_item(CMD_DISPATCH, 4'd0, 3'd0);
    send_item(CMD_NOP, 4'd15, 3'd7);
    send_item(CMD_REMOVE, 4'd15, 3'd0);
    send_item(CMD_REMOVE, 4'd9, 3'd0);
    send_item(CMD_DISPATCH, 4'd0, 3'd0);
    send_item(CMD_REMOVE, 4'd9, 3'd0);
    send_item(CMD_REMOVE, 4'd6, 3'd0);
    send_item(CMD_REMOVE, 4'd0, 3'd0);
    send_item(CMD_DISPATCH, 4'd0, 3'd0);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int s_pct, int r_pct);
    int sel;
    pid_t p;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 97 == 50) wait_drained();
      sel = $urandom_range(99);
      p = pid_t'($urandom_range(NUM_PROCESSES - 1));
      if (sel < 40) begin
        for (int k = 0; k < 3 && is_queued[p]; k++) p = pid_t'($urandom_range(15));
        send_item(CMD_ADD, p, 3'($urandom_range(7)));
      end else if (sel < 72) begin
        for (int k = 0; k < 3 && !is_queued[p]; k++) p = pid_t'($urandom_range(15));
        send_item(CMD_REMOVE, p, 3'($urandom_range(7)));
      end else if (sel < 96) begin
        send_item(CMD_DISPATCH, p, 3'($urandom_range(7)));
      end else begin
        send_item(CMD_NOP, p, 3'($urandom_range(7)));
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_PROCESSES; i++) is_queued[i] = 1'b0;
    ready_mask = '0;
    running = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(330, 12, 84);
    test_random(330, 84, 12);
    test_random(340, 0, 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/prrq_pkg.sv
src/priority_round_robin_ready_queue_unit.sv
src/prrq_checker.sv
test/priority_round_robin_ready_queue_unit_tb.sv
